@@ rtl/bmmd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmmd_pkg
// Shared types and constants of the bucket min/max/mean decimator.
// ----------------------------------------------------------------------------
package bmmd_pkg;

	localparam int CNT_W      = 21;
	localparam int MAXB_W     = 13;
	localparam int FRAME_W    = 32;
	localparam int VALUE_W    = 32;
	localparam int SUM_W      = 52;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	localparam int MAX_SERIES  = 1048576;
	localparam int TOTAL_RESET = 0;
	localparam int MAXB_RESET  = 1024;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOTAL_POINTS = 1'b0,
		CFG_MAX_BUCKETS  = 1'b1
	} cfg_index_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} back_state_t;

	// closed bucket, handed from front to back
	typedef struct packed {
		logic [FRAME_W-1:0]        first_frame;
		logic [FRAME_W-1:0]        final_frame;
		logic [CNT_W-1:0]          record_total;
		logic [CNT_W-1:0]          valid_total;
		logic signed [SUM_W-1:0]   value_sum;
		logic signed [VALUE_W-1:0] value_min;
		logic signed [VALUE_W-1:0] value_max;
		logic                      last_bucket;
	} bucket_t;

	typedef struct packed {
		bucket_t                   bucket;
		logic signed [VALUE_W-1:0] value_mean;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/bmmd_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmmd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmmd_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [NUM_W-1:0]      quo
);

	localparam int CNT_BITS = $clog2(NUM_W + 1);

	logic                busy_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DEN_W-1:0]    den_q;
	logic [DEN_W-1:0]    rem_q;
	logic [NUM_W-1:0]    quo_q;
	logic [DEN_W:0]      shifted;
	logic [DEN_W:0]      diff;
	logic                ge;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		ge      = shifted >= {1'b0, den_q};
		diff    = shifted - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(NUM_W);
		end else if (busy_q) begin
			busy_q <= cnt_q != CNT_BITS'(1);
			cnt_q  <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

@@ rtl/bmmd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmmd_front
// Configuration registers, bucket width, per-point accumulation.
// ----------------------------------------------------------------------------
module bmmd_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	input  wire logic [bmmd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [bmmd_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                   pt_valid,
	output logic                                        pt_ready,
	input  wire logic [bmmd_pkg::FRAME_W-1:0]           pt_frame,
	input  wire logic                                   pt_has,
	input  wire logic signed [bmmd_pkg::VALUE_W-1:0]    sample_value,
	output logic                                        push,
	output bmmd_pkg::bucket_t                           push_data,
	input  wire logic                                   queue_full
);

	localparam int CW = bmmd_pkg::CNT_W;
	localparam int MW = bmmd_pkg::MAXB_W;
	localparam int SW = bmmd_pkg::SUM_W;
	localparam int VW = bmmd_pkg::VALUE_W;

	logic [CW-1:0]              total_q;
	logic [MW-1:0]              maxb_q;
	logic                       wpend_q;
	logic [CW-1:0]              seen_q;
	logic [CW-1:0]              inbkt_q;
	logic [CW-1:0]              vcnt_q;
	logic [bmmd_pkg::FRAME_W-1:0] start_frame_q;
	logic signed [SW-1:0]       sum_q;
	logic signed [VW-1:0]       min_q;
	logic signed [VW-1:0]       max_q;

	logic [CW-1:0]   total_eff;
	logic [MW-1:0]   mb;
	logic [CW:0]     wnum;
	logic            wbusy;
	logic [CW:0]     wquo;
	logic [CW-1:0]   width;
	logic            cfg_wr;
	logic            take;

	logic [CW-1:0]              pib;
	logic [CW-1:0]              seen_n;
	logic [CW-1:0]              vcnt_n;
	logic [bmmd_pkg::FRAME_W-1:0] sf;
	logic signed [SW:0]         sum_wide;
	logic signed [SW-1:0]       sum_n;
	logic signed [VW-1:0]       min_n;
	logic signed [VW-1:0]       max_n;
	logic                       last;
	logic                       close;

	assign total_eff = (total_q > CW'(bmmd_pkg::MAX_SERIES)) ? CW'(bmmd_pkg::MAX_SERIES)
	                                                          : total_q;
	assign mb    = (maxb_q == '0) ? MW'(1) : maxb_q;
	assign wnum  = {1'b0, total_eff} + (CW + 1)'(mb) - (CW + 1)'(1);
	assign width = wquo[CW-1:0];

	bmmd_div #(
		.NUM_W (CW + 1),
		.DEN_W (MW)
	) u_wdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wpend_q),
		.num    (wnum),
		.den    (mb),
		.busy   (wbusy),
		.quo    (wquo)
	);

	assign cfg_wr   = cfg_valid;
	assign pt_ready = !wpend_q && !wbusy && !queue_full;
	assign take     = pt_valid && pt_ready && (total_eff != '0);

	always_comb begin
		pib      = inbkt_q + CW'(1);
		seen_n   = seen_q + CW'(1);
		sf       = (inbkt_q == '0) ? pt_frame : start_frame_q;
		vcnt_n   = vcnt_q;
		sum_n    = sum_q;
		min_n    = min_q;
		max_n    = max_q;
		sum_wide = {sum_q[SW-1], sum_q} + (SW + 1)'(sample_value);
		if (pt_has) begin
			vcnt_n = vcnt_q + CW'(1);
			if (vcnt_q == '0 || sample_value < min_q) begin
				min_n = sample_value;
			end
			if (vcnt_q == '0 || sample_value > max_q) begin
				max_n = sample_value;
			end
			if (sum_wide[SW] != sum_wide[SW-1]) begin
				sum_n = sum_wide[SW] ? bmmd_pkg::SUM_MIN : bmmd_pkg::SUM_MAX;
			end else begin
				sum_n = sum_wide[SW-1:0];
			end
		end
		last  = seen_n >= total_eff;
		close = (pib >= width) || last;
	end

	always_comb begin
		push_data.first_frame  = sf;
		push_data.final_frame  = pt_frame;
		push_data.record_total = pib;
		push_data.valid_total  = vcnt_n;
		push_data.value_sum    = sum_n;
		push_data.value_min    = min_n;
		push_data.value_max    = max_n;
		push_data.last_bucket  = last;
	end
	assign push = take && close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= CW'(bmmd_pkg::TOTAL_RESET);
			maxb_q        <= MW'(bmmd_pkg::MAXB_RESET);
			wpend_q       <= 1'b1;
			seen_q        <= '0;
			inbkt_q       <= '0;
			vcnt_q        <= '0;
			start_frame_q <= '0;
			sum_q         <= '0;
			min_q         <= '0;
			max_q         <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				bmmd_pkg::CFG_TOTAL_POINTS: total_q <= cfg_data[CW-1:0];
				bmmd_pkg::CFG_MAX_BUCKETS:  maxb_q  <= cfg_data[MW-1:0];
				default: ;
			endcase
			wpend_q       <= 1'b1;
			seen_q        <= '0;
			inbkt_q       <= '0;
			vcnt_q        <= '0;
			start_frame_q <= '0;
			sum_q         <= '0;
			min_q         <= '0;
			max_q         <= '0;
		end else begin
			wpend_q <= 1'b0;
			if (take) begin
				if (close) begin
					seen_q        <= last ? '0 : seen_n;
					inbkt_q       <= '0;
					vcnt_q        <= '0;
					sum_q         <= '0;
					min_q         <= '0;
					max_q         <= '0;
					start_frame_q <= last ? '0 : sf;
				end else begin
					seen_q        <= seen_n;
					inbkt_q       <= pib;
					vcnt_q        <= vcnt_n;
					sum_q         <= sum_n;
					min_q         <= min_n;
					max_q         <= max_n;
					start_frame_q <= sf;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bmmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmmd_fifo
// Short queue of closed buckets between front and back.
// ----------------------------------------------------------------------------
module bmmd_fifo #(
	parameter int DEPTH = bmmd_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bmmd_pkg::bucket_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output bmmd_pkg::bucket_t      pop_data,
	output logic                   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	bmmd_pkg::bucket_t mem [DEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [NW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == NW'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bmmd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmmd_back
// Mean division and output register for closed buckets.
// ----------------------------------------------------------------------------
module bmmd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              queue_empty,
	input  wire bmmd_pkg::bucket_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bmmd_pkg::result_t      out_data
);

	localparam int SW = bmmd_pkg::SUM_W;
	localparam int VW = bmmd_pkg::VALUE_W;
	localparam int CW = bmmd_pkg::CNT_W;

	bmmd_pkg::back_state_t state_q;
	bmmd_pkg::back_state_t state_n;
	bmmd_pkg::bucket_t     rec_q;
	bmmd_pkg::result_t     out_q;
	logic                  out_valid_q;

	logic            out_free;
	logic            div_start;
	logic            load;
	logic [SW-1:0]   mag;
	logic            div_busy;
	logic [SW-1:0]   quo;
	logic [VW-1:0]   mean;

	assign out_free = !out_valid_q || out_ready;
	assign mag      = head.value_sum[SW-1] ? SW'(-head.value_sum) : SW'(head.value_sum);

	bmmd_div #(
		.NUM_W (SW),
		.DEN_W (CW)
	) u_mdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mag),
		.den    (head.valid_total),
		.busy   (div_busy),
		.quo    (quo)
	);

	always_comb begin
		if (rec_q.valid_total == '0) begin
			mean = '0;
		end else if (rec_q.value_sum[SW-1]) begin
			mean = -quo[VW-1:0];
		end else begin
			mean = quo[VW-1:0];
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			bmmd_pkg::BK_IDLE: if (!queue_empty) state_n = bmmd_pkg::BK_DIV;
			bmmd_pkg::BK_DIV:  if (!div_busy && out_free) state_n = bmmd_pkg::BK_IDLE;
			default:           state_n = bmmd_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			bmmd_pkg::BK_IDLE: begin
				pop       = !queue_empty;
				div_start = !queue_empty;
			end
			bmmd_pkg::BK_DIV: begin
				load = !div_busy && out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bmmd_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head;
		end
		if (load) begin
			out_q.bucket     <= rec_q;
			out_q.value_mean <= mean;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ rtl/bucket_min_max_mean_decimator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bucket_min_max_mean_decimator_top
// Groups a stream of series points into buckets and reports min/max/mean.
// ----------------------------------------------------------------------------
// Points are taken at one per cycle while the width divider is idle and
// the queue is not full; each point is folded into the current bucket in
// the cycle it is accepted. A closed bucket goes into a queue of
// QUEUE_DEPTH entries, and the back end handles one bucket at a time:
// a one-bit-per-cycle divider forms the mean, then the result is registered,
// and only then is the next bucket taken from the queue.
// After reset and after each configuration write the bucket width is
// recomputed by a serial divider, and no point is taken until it is done.
// ----------------------------------------------------------------------------
module bucket_min_max_mean_decimator_top #(
	parameter int QUEUE_DEPTH = bmmd_pkg::QUEUE_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bmmd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bmmd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// point frame [31:0], sample_value [63:32]
	input  wire logic [63:0]                         s_axis_tdata,
	// value present flag [0]
	input  wire logic [0:0]                          s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// first_frame [31:0], final_frame [63:32], record_total [84:64],
	// valid_total [105:85], value_sum [157:106], value_min [189:158],
	// value_max [221:190], value_mean [253:222], zero [255:254]
	output logic [255:0]                             m_axis_tdata,
	// last_bucket
	output logic                                     m_axis_tlast
);

	bmmd_pkg::bucket_t push_data;
	bmmd_pkg::bucket_t head;
	bmmd_pkg::result_t res;
	logic              push;
	logic              full;
	logic              pop;
	logic              empty;

	assign cfg_ready = 1'b1;

	bmmd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pt_valid     (s_axis_tvalid),
		.pt_ready     (s_axis_tready),
		.pt_frame     (s_axis_tdata[31:0]),
		.pt_has       (s_axis_tuser[0]),
		.sample_value (s_axis_tdata[63:32]),
		.push         (push),
		.push_data    (push_data),
		.queue_full   (full)
	);

	bmmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	bmmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (res)
	);

	assign m_axis_tdata = {
		2'b00,
		res.value_mean,
		res.bucket.value_max,
		res.bucket.value_min,
		res.bucket.value_sum,
		res.bucket.valid_total,
		res.bucket.record_total,
		res.bucket.final_frame,
		res.bucket.first_frame
	};
	assign m_axis_tlast = res.bucket.last_bucket;

endmodule
`default_nettype wire
